@@ rtl/core/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg
// Shared constants, codes and the control/status types of the line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_CAPACITY = 16;
  localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
  localparam int STORE_AW      = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_EOT    = 8'h04;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_UP_C   = 8'h43;
  localparam logic [7:0] CH_UP_D   = 8'h44;

  localparam logic [2:0] COUNT_NONE  = 3'd0;
  localparam logic [2:0] COUNT_ARROW = 3'd3;

  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_LINE,
    KIND_END,
    KIND_EOF
  } kind_t;

  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_EOF,
    KEY_CR,
    KEY_LEFT,
    KEY_RIGHT,
    KEY_PRINT,
    KEY_ERASE
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR,
    S_LF,
    S_LINE,
    S_FINAL,
    S_LEFT,
    S_RIGHT,
    S_INS_SHIFT,
    S_INS_TAIL,
    S_DEL_SHIFT,
    S_DEL_BS,
    S_DEL_TAIL,
    S_SPACE,
    S_BACK
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_LEN,
    IDX_LOAD_CUR,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_LOAD_TAIL,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_PUT
  } st_op_t;

  typedef enum logic [1:0] {
    REG_HOLD,
    REG_INC,
    REG_DEC,
    REG_CLEAR
  } reg_op_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_STORE,
    SRC_LEN
  } src_t;

  typedef struct packed {
    logic       idle;
    logic       capture;
    idx_op_t    idx_op;
    cnt_op_t    cnt_op;
    st_op_t     st_op;
    reg_op_t    len_op;
    reg_op_t    cur_op;
    logic       emit;
    src_t       src;
    kind_t      kind;
    logic [7:0] byte_val;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    key_t key;
    logic idx_eq_len;
    logic idx_eq_cur;
    logic idx_is_last;
    logic cnt_zero;
    logic cnt_one;
    logic len_zero;
    logic emit_ok;
  } sts_t;

endpackage

@@ rtl/core/tle_chan_if.sv @@
// ----------------------------------------------------------------------------
// tle_chan_if
// Valid/ready channels of the line editor: key chunk in, echo word out.
// ----------------------------------------------------------------------------
interface tle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [2:0] byte_count;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  output byte_count, input ready);
  modport sink (input valid, input byte0, input byte1, input byte2, input byte3,
                input byte_count, output ready);
endinterface

interface tle_tx_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink (input valid, input kind, input data, input last, output ready);
endinterface

@@ rtl/core/tle_datapath.sv @@
// ----------------------------------------------------------------------------
// tle_datapath
// Key decode, line store with length/cursor, index counters, output register.
// ----------------------------------------------------------------------------
module tle_datapath (
  input  logic          clk,
  input  logic          rst,
  tle_rx_if.sink        rx,
  tle_tx_if.source      tx,
  input  tle_pkg::cmd_t cmd,
  output tle_pkg::sts_t sts
);
  import tle_pkg::*;

  logic [7:0]          store [LINE_CAPACITY];
  logic [LEN_W-1:0]    length;
  logic [LEN_W-1:0]    cursor;
  logic [LEN_W-1:0]    idx;
  logic [LEN_W-1:0]    cnt;
  logic [7:0]          ch;
  logic [LEN_W-1:0]    idx_m1;
  logic [LEN_W-1:0]    idx_p1;
  logic [STORE_AW-1:0] rd_addr;
  logic [STORE_AW-1:0] wr_addr;
  logic [7:0]          rd_data;
  logic [7:0]          wr_data;
  logic [7:0]          emit_data;
  logic                out_valid;
  logic [1:0]          out_kind;
  logic [7:0]          out_data;
  logic                out_last;
  logic                chunk_eof;
  key_t                key;

  assign idx_m1 = idx - LEN_W'(1);
  assign idx_p1 = idx + LEN_W'(1);

  // one read port: shift-up reads the entry below idx
  assign rd_addr = (cmd.st_op == ST_SHIFT_UP) ? idx_m1[STORE_AW-1:0] : idx[STORE_AW-1:0];
  assign rd_data = store[rd_addr];

  always_comb begin
    case (cmd.st_op)
      ST_SHIFT_UP:   wr_addr = idx[STORE_AW-1:0];
      ST_SHIFT_DOWN: wr_addr = idx_m1[STORE_AW-1:0];
      ST_PUT:        wr_addr = cursor[STORE_AW-1:0];
      default:       wr_addr = idx[STORE_AW-1:0];
    endcase
    wr_data = (cmd.st_op == ST_PUT) ? ch : rd_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.st_op != ST_NONE) begin
      store[wr_addr] <= wr_data;
    end
  end

  // key decode
  assign chunk_eof = (rx.byte_count == COUNT_NONE) || (rx.byte0 == CH_EOT) ||
                     (rx.byte0 == CH_ETX);

  always_comb begin
    key = KEY_NONE;
    if (chunk_eof) begin
      key = KEY_EOF;
    end else if (rx.byte0 == CH_CR) begin
      key = KEY_CR;
    end else if (rx.byte0 == CH_ESC) begin
      if (rx.byte_count == COUNT_ARROW && rx.byte1 == CH_LBRACK) begin
        if (rx.byte2 == CH_UP_D && cursor != '0) begin
          key = KEY_LEFT;
        end else if (rx.byte2 == CH_UP_C && cursor < length) begin
          key = KEY_RIGHT;
        end
      end
    end else if (rx.byte0 inside {[CH_SP:CH_TILDE]}) begin
      if (length < LEN_W'(LINE_CAPACITY)) begin
        key = KEY_PRINT;
      end
    end else if (rx.byte0 inside {CH_BS, CH_DEL}) begin
      if (cursor != '0) begin
        key = KEY_ERASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch <= rx.byte0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      cursor <= '0;
      idx    <= '0;
      cnt    <= '0;
    end else begin
      case (cmd.len_op)
        REG_INC:   length <= length + LEN_W'(1);
        REG_DEC:   length <= length - LEN_W'(1);
        REG_CLEAR: length <= '0;
        default:   length <= length;
      endcase
      case (cmd.cur_op)
        REG_INC:   cursor <= cursor + LEN_W'(1);
        REG_DEC:   cursor <= cursor - LEN_W'(1);
        REG_CLEAR: cursor <= '0;
        default:   cursor <= cursor;
      endcase
      case (cmd.idx_op)
        IDX_LOAD_LEN: idx <= length;
        IDX_LOAD_CUR: idx <= cursor;
        IDX_ZERO:     idx <= '0;
        IDX_INC:      idx <= idx_p1;
        IDX_DEC:      idx <= idx_m1;
        default:      idx <= idx;
      endcase
      case (cmd.cnt_op)
        CNT_LOAD_TAIL: cnt <= length - cursor;
        CNT_INC:       cnt <= cnt + LEN_W'(1);
        CNT_DEC:       cnt <= cnt - LEN_W'(1);
        default:       cnt <= cnt;
      endcase
    end
  end

  // output word register
  always_comb begin
    case (cmd.src)
      SRC_CONST: emit_data = cmd.byte_val;
      SRC_STORE: emit_data = rd_data;
      SRC_LEN:   emit_data = 8'(length);
      default:   emit_data = cmd.byte_val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_data <= emit_data;
      out_last <= cmd.last;
    end
  end

  assign tx.valid = out_valid;
  assign tx.kind  = out_kind;
  assign tx.data  = out_data;
  assign tx.last  = out_last;
  assign rx.ready = cmd.idle;

  assign sts.in_valid    = rx.valid;
  assign sts.key         = key;
  assign sts.idx_eq_len  = (idx == length);
  assign sts.idx_eq_cur  = (idx == cursor);
  assign sts.idx_is_last = (idx_p1 == length);
  assign sts.cnt_zero    = (cnt == '0);
  assign sts.cnt_one     = (cnt == LEN_W'(1));
  assign sts.len_zero    = (length == '0);
  assign sts.emit_ok     = !out_valid || tx.ready;

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst) cursor <= length)
    else $error("cursor beyond line end");
  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(LINE_CAPACITY))
    else $error("line length beyond capacity");
  a_emit_room: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> sts.emit_ok)
    else $error("word emitted over a pending word");
  a_no_edit_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.st_op != ST_NONE) |-> !rx.ready)
    else $error("line store written while idle");
`endif

endmodule

@@ rtl/core/tle_ctrl.sv @@
// ----------------------------------------------------------------------------
// tle_ctrl
// Sequencer: picks the edit per key and steps shifts and echo words.
// ----------------------------------------------------------------------------
module tle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  tle_pkg::sts_t sts,
  output tle_pkg::cmd_t cmd
);
  import tle_pkg::*;

  state_t state;
  state_t state_next;
  logic   is_eof;
  logic   is_eof_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      is_eof <= 1'b0;
    end else begin
      state  <= state_next;
      is_eof <= is_eof_next;
    end
  end

  always_comb begin
    cmd         = '0;
    state_next  = state;
    is_eof_next = is_eof;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          cmd.capture = 1'b1;
          case (sts.key)
            KEY_EOF: begin
              is_eof_next = 1'b1;
              state_next  = S_CR;
            end
            KEY_CR: begin
              is_eof_next = 1'b0;
              state_next  = S_CR;
            end
            KEY_LEFT: state_next = S_LEFT;
            KEY_RIGHT: begin
              cmd.idx_op = IDX_LOAD_CUR;
              state_next = S_RIGHT;
            end
            KEY_PRINT: begin
              cmd.idx_op = IDX_LOAD_LEN;
              state_next = S_INS_SHIFT;
            end
            KEY_ERASE: begin
              cmd.idx_op = IDX_LOAD_CUR;
              cmd.cnt_op = CNT_LOAD_TAIL;
              state_next = S_DEL_SHIFT;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CR: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_CONST;
          cmd.kind     = KIND_ECHO;
          cmd.byte_val = CH_CR;
          state_next   = S_LF;
        end
      end
      S_LF: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_CONST;
          cmd.kind     = KIND_ECHO;
          cmd.byte_val = CH_LF;
          cmd.idx_op   = IDX_ZERO;
          state_next   = (is_eof || sts.len_zero) ? S_FINAL : S_LINE;
        end
      end
      S_LINE: begin
        if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_STORE;
          cmd.kind   = KIND_LINE;
          cmd.idx_op = IDX_INC;
          if (sts.idx_is_last) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = is_eof ? SRC_CONST : SRC_LEN;
          cmd.kind     = is_eof ? KIND_EOF : KIND_END;
          cmd.byte_val = CH_NUL;
          cmd.last     = 1'b1;
          cmd.len_op   = REG_CLEAR;
          cmd.cur_op   = REG_CLEAR;
          state_next   = S_IDLE;
        end
      end
      S_LEFT: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_CONST;
          cmd.kind     = KIND_ECHO;
          cmd.byte_val = CH_BS;
          cmd.last     = 1'b1;
          cmd.cur_op   = REG_DEC;
          state_next   = S_IDLE;
        end
      end
      S_RIGHT: begin
        if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_STORE;
          cmd.kind   = KIND_ECHO;
          cmd.last   = 1'b1;
          cmd.cur_op = REG_INC;
          state_next = S_IDLE;
        end
      end
      S_INS_SHIFT: begin
        if (sts.idx_eq_cur) begin
          cmd.st_op  = ST_PUT;
          cmd.len_op = REG_INC;
          cmd.cur_op = REG_INC;
          cmd.idx_op = IDX_LOAD_CUR;
          cmd.cnt_op = CNT_LOAD_TAIL;
          state_next = S_INS_TAIL;
        end else begin
          cmd.st_op  = ST_SHIFT_UP;
          cmd.idx_op = IDX_DEC;
        end
      end
      S_INS_TAIL: begin
        if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_STORE;
          cmd.kind   = KIND_ECHO;
          cmd.last   = sts.idx_is_last && sts.cnt_zero;
          cmd.idx_op = IDX_INC;
          if (sts.idx_is_last) begin
            state_next = sts.cnt_zero ? S_IDLE : S_BACK;
          end
        end
      end
      S_DEL_SHIFT: begin
        if (sts.idx_eq_len) begin
          cmd.len_op = REG_DEC;
          cmd.cur_op = REG_DEC;
          state_next = S_DEL_BS;
        end else begin
          cmd.st_op  = ST_SHIFT_DOWN;
          cmd.idx_op = IDX_INC;
        end
      end
      S_DEL_BS: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_CONST;
          cmd.kind     = KIND_ECHO;
          cmd.byte_val = CH_BS;
          cmd.idx_op   = IDX_LOAD_CUR;
          state_next   = sts.cnt_zero ? S_SPACE : S_DEL_TAIL;
        end
      end
      S_DEL_TAIL: begin
        if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.src    = SRC_STORE;
          cmd.kind   = KIND_ECHO;
          cmd.idx_op = IDX_INC;
          if (sts.idx_is_last) begin
            state_next = S_SPACE;
          end
        end
      end
      S_SPACE: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_CONST;
          cmd.kind     = KIND_ECHO;
          cmd.byte_val = CH_SP;
          cmd.cnt_op   = CNT_INC;
          state_next   = S_BACK;
        end
      end
      S_BACK: begin
        if (sts.emit_ok) begin
          cmd.emit     = 1'b1;
          cmd.src      = SRC_CONST;
          cmd.kind     = KIND_ECHO;
          cmd.byte_val = CH_BS;
          cmd.last     = sts.cnt_one;
          cmd.cnt_op   = CNT_DEC;
          if (sts.cnt_one) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/terminal_line_editor.sv @@
// ----------------------------------------------------------------------------
// terminal_line_editor
// Raw-mode line editor: decodes a key per chunk, edits the line, echoes words.
// ----------------------------------------------------------------------------
// one chunk at a time; one output word per cycle when the sink is ready, outside shifts
// insert: shifts the tail up, puts the character, then echoes it, the tail and backspaces
// erase: shifts the tail down, then echoes a backspace, the tail, a space and backspaces
// cr: length + 3 words; arrows and eof: 1 to 3 words; ignored keys: no words
// rate is set by the line store's single read and write ports and the one-word output register
// sync reset clears length, cursor, sequencer and output valid; store is not cleared
module terminal_line_editor (
  input  logic     clk,
  input  logic     rst,
  tle_rx_if.sink   rx,
  tle_tx_if.source tx
);
  import tle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tle_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  tle_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
